// ===== hdl/histogram_quantile_contrast_stretch_assert.svh =====
// Assertion macros for the contrast stretch block.
`ifndef HISTOGRAM_QUANTILE_CONTRAST_STRETCH_ASSERT_SVH
`define HISTOGRAM_QUANTILE_CONTRAST_STRETCH_ASSERT_SVH
`ifndef SYNTH
`define HQCS_ASSERT_SAME(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("hqcs assertion failed");
`define HQCS_ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("hqcs assertion failed");
`else
`define HQCS_ASSERT_SAME(lbl, ck, rn, a, c)
`define HQCS_ASSERT_NEXT(lbl, ck, rn, a, c)
`endif
`endif

// ===== hdl/hqcs_pkg.sv =====
// Types and constants for the contrast stretch block.
package hqcs_pkg;

  localparam logic OP_COLLECT = 1'b0;
  localparam logic OP_APPLY   = 1'b1;

  localparam logic KIND_BOUNDS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [1:0] REG_TARGET_MIN = 2'd0;
  localparam logic [1:0] REG_TARGET_MAX = 2'd1;
  localparam logic [1:0] REG_FLAT_LOW   = 2'd2;
  localparam logic [1:0] REG_FLAT_HIGH  = 2'd3;

  localparam int CFG_W  = 21;
  localparam int BINS   = 256;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel;
    logic       last;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_out;
    logic [7:0] low_bound;
    logic [7:0] high_bound;
  } out_t;

endpackage

// ===== hdl/hqcs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hqcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/histogram_quantile_contrast_stretch.sv =====
// Top level: histogram contrast stretch with bin memory, bound walk and divider.
//
//  port group | dir | handshake         | payload
//  in_        | in  | in_valid/in_ready | hqcs_pkg::in_t
//  out_       | out | out_valid/out_ready | hqcs_pkg::out_t
//  cfg_       | in  | cfg_we            | cfg_index, cfg_wdata
//
// Collect item: bin read, then bin write back through the one RAM port pair.
// Last collect item: then walks all 256 bins, clearing each as read, and posts the bounds.
// Apply item: trivial cases go straight to the output; others use the 16-step serial divider.
// After reset, all 256 bins of the RAM are cleared before the first item is taken.
// A result waits in the output register; the next item is taken meanwhile.
`include "histogram_quantile_contrast_stretch_assert.svh"
module histogram_quantile_contrast_stretch #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hqcs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hqcs_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [20:0]    cfg_wdata
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = CW + 8;
  localparam int LW = (SW > 22) ? SW : 22;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CWR, S_WALK, S_WEND, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t         state_r;
  logic [7:0]     tmin_r, tmax_r;
  logic [20:0]    flo_r, fhi_r;
  logic [CW-1:0]  cnt_r;
  logic [7:0]     rmin_r, rmax_r, lo_r, hi_r;
  logic [7:0]     pix_r;
  logic           last_r;
  logic [8:0]     wk_r;
  logic [LW-1:0]  cum_r, fle_r, thr_r;
  logic           mm_r, lf_r, hf_r;
  logic [7:0]     lb_r, hb_r;
  logic           neg_r;
  logic [7:0]     den_r;
  logic [15:0]    quo_r;
  logic [8:0]     rem_r;
  logic [4:0]     dcnt_r;
  hqcs_pkg::out_t res_r;
  logic           out_valid_r;
  hqcs_pkg::out_t out_r;

  logic           ram_we;
  logic [7:0]     ram_waddr, ram_raddr;
  logic [CW-1:0]  ram_wdata, ram_rdata;

  logic [LW-1:0]  n_l, sum_l, half_l, fle_nxt, fhe_nxt, cum_nxt;
  logic [8:0]     dsh, rem_nxt;
  logic           dge;
  logic [8:0]     d9;
  logic [7:0]     dmag;
  logic [8:0]     mid9;
  logic [7:0]     qf;
  logic [7:0]     wb;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    ram_raddr = in_data.pixel;
    if (state_r == S_WALK) begin
      ram_raddr = wk_r[7:0];
    end
    wb        = 8'(wk_r - 9'd1);
    ram_we    = 1'b0;
    ram_waddr = pix_r;
    ram_wdata = '0;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = wk_r[7:0];
      end
      S_CWR: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata < CW'(MAX_PIXELS)) ? CW'(ram_rdata + 1'b1) : ram_rdata;
      end
      S_WALK: begin
        ram_we    = (wk_r != 9'd0);
        ram_waddr = wb;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    n_l     = LW'(cnt_r);
    sum_l   = LW'(flo_r) + LW'(fhi_r);
    half_l  = (n_l - 1'b1) >> 1;
    fle_nxt = (sum_l >= n_l) ? half_l : LW'(flo_r);
    fhe_nxt = (sum_l >= n_l) ? half_l : LW'(fhi_r);
    cum_nxt = cum_r + LW'(ram_rdata);
    dsh     = {rem_r[7:0], quo_r[15]};
    dge     = (dsh >= {1'b0, den_r});
    rem_nxt = dge ? (dsh - {1'b0, den_r}) : dsh;
    d9      = {1'b0, tmax_r} - {1'b0, tmin_r};
    dmag    = d9[8] ? 8'(-d9) : d9[7:0];
    mid9    = ({1'b0, tmin_r} + {1'b0, tmax_r}) >> 1;
    qf      = neg_r ? 8'(-(quo_r[7:0] + 8'(rem_r != 9'd0))) : quo_r[7:0];
  end

  hqcs_ram #(.WIDTH(CW), .DEPTH(hqcs_pkg::BINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      tmin_r      <= 8'd0;
      tmax_r      <= 8'd255;
      flo_r       <= '0;
      fhi_r       <= '0;
      cnt_r       <= '0;
      rmin_r      <= 8'd255;
      rmax_r      <= 8'd0;
      lo_r        <= 8'd0;
      hi_r        <= 8'd0;
      wk_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hqcs_pkg::REG_TARGET_MIN: tmin_r <= cfg_wdata[7:0];
          hqcs_pkg::REG_TARGET_MAX: tmax_r <= cfg_wdata[7:0];
          hqcs_pkg::REG_FLAT_LOW:   flo_r  <= cfg_wdata;
          hqcs_pkg::REG_FLAT_HIGH:  fhi_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          wk_r <= wk_r + 1'b1;
          if (wk_r == 9'd255) begin
            wk_r    <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            pix_r  <= in_data.pixel;
            last_r <= in_data.last;
            if (in_data.operation == hqcs_pkg::OP_COLLECT) begin
              if (cnt_r < CW'(MAX_PIXELS)) cnt_r <= cnt_r + 1'b1;
              if (in_data.pixel < rmin_r) rmin_r <= in_data.pixel;
              if (in_data.pixel > rmax_r) rmax_r <= in_data.pixel;
              state_r <= S_CWR;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_CWR: begin
          fle_r   <= fle_nxt;
          thr_r   <= n_l - fhe_nxt;
          mm_r    <= (fle_nxt == '0) && (fhe_nxt == '0);
          cum_r   <= '0;
          lf_r    <= 1'b0;
          hf_r    <= 1'b0;
          lb_r    <= 8'd0;
          hb_r    <= 8'd0;
          wk_r    <= '0;
          state_r <= last_r ? S_WALK : S_IDLE;
        end
        S_WALK: begin
          wk_r <= wk_r + 1'b1;
          if (wk_r != 9'd0) begin
            cum_r <= cum_nxt;
            if (!lf_r && (cum_nxt > fle_r)) begin
              lf_r <= 1'b1;
              lb_r <= wb;
            end
            if (cum_nxt <= thr_r) begin
              hf_r <= 1'b1;
              hb_r <= wb;
            end
          end
          if (wk_r == 9'd256) begin
            state_r <= S_WEND;
          end
        end
        S_WEND: begin
          res_r.kind      <= hqcs_pkg::KIND_BOUNDS;
          res_r.pixel_out <= 8'd0;
          if (mm_r) begin
            lo_r             <= rmin_r;
            hi_r             <= rmax_r;
            res_r.low_bound  <= rmin_r;
            res_r.high_bound <= rmax_r;
          end else begin
            lo_r             <= !lf_r ? 8'd255 : (lb_r != 8'd0) ? lb_r - 1'b1 : 8'd0;
            res_r.low_bound  <= !lf_r ? 8'd255 : (lb_r != 8'd0) ? lb_r - 1'b1 : 8'd0;
            hi_r             <= !hf_r ? 8'd0 : (hb_r != 8'd255) ? hb_r + 1'b1 : 8'd255;
            res_r.high_bound <= !hf_r ? 8'd0 : (hb_r != 8'd255) ? hb_r + 1'b1 : 8'd255;
          end
          cnt_r   <= '0;
          rmin_r  <= 8'd255;
          rmax_r  <= 8'd0;
          state_r <= S_OUT;
        end
        S_MUL: begin
          res_r.kind       <= hqcs_pkg::KIND_PIXEL;
          res_r.low_bound  <= lo_r;
          res_r.high_bound <= hi_r;
          quo_r   <= 16'(pix_r - lo_r) * 16'(dmag);
          den_r   <= hi_r - lo_r;
          neg_r   <= d9[8];
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_OUT;
          if (tmin_r == tmax_r) begin
            res_r.pixel_out <= tmin_r;
          end else if (hi_r <= lo_r) begin
            res_r.pixel_out <= mid9[7:0];
          end else if (pix_r < lo_r) begin
            res_r.pixel_out <= tmin_r;
          end else if (pix_r >= hi_r) begin
            res_r.pixel_out <= tmax_r;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[14:0], dge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd15) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r.pixel_out <= tmin_r + qf;
          state_r         <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r       <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `HQCS_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  `HQCS_ASSERT_SAME(a_cnt_sat, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_PIXELS))
  `HQCS_ASSERT_SAME(a_div_cnt, clk, rst_n, state_r == S_DIV, dcnt_r <= 5'd15)
  `HQCS_ASSERT_SAME(a_walk_span, clk, rst_n, state_r == S_WALK, wk_r <= 9'd256)

endmodule

// ===== dv/histogram_quantile_contrast_stretch_tb.sv =====
// Self-checking testbench for the histogram contrast stretch block.
module histogram_quantile_contrast_stretch_tb;

  localparam int MAXPIX    = 1048576;
  localparam int WDOG_MAX  = 20000;
  localparam int SETTLE    = 300;
  localparam int RAND_ITEMS = 1650;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  hqcs_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  hqcs_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [20:0]    cfg_wdata = '0;

  histogram_quantile_contrast_stretch uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // stretch model state
  logic [7:0]  m_tmin = 8'd0, m_tmax = 8'd255;
  logic [20:0] m_flat_lo = '0, m_flat_hi = '0;
  int unsigned hist [256];
  int unsigned pix_cnt = 0;
  logic [7:0]  run_min = 8'd255, run_max = 8'd0;
  logic [7:0]  cut_lo = 8'd0, cut_hi = 8'd0;

  hqcs_pkg::in_t  pending_items [$];
  hqcs_pkg::out_t expected_results [$];
  int   errors = 0;
  int   in_gap = 0;
  int   out_hold = 0;
  int   results_seen = 0;
  bit   pressure_done = 0;
  int   idle_cycles = 0;

  initial foreach (hist[i]) hist[i] = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void frame_bounds();
    longint n, fl, fh, acc;
    longint cum [256];
    int b;
    n = pix_cnt; fl = m_flat_lo; fh = m_flat_hi; acc = 0;
    if (fl + fh >= n) begin
      fl = (n - 1) / 2;
      fh = fl;
    end
    if (fl == 0 && fh == 0) begin
      cut_lo = run_min;
      cut_hi = run_max;
      return;
    end
    for (int i = 0; i < 256; i++) begin
      acc += hist[i];
      cum[i] = acc;
    end
    b = 0;
    while (b < 256 && cum[b] <= fl) b++;
    if (b > 0) b--;
    cut_lo = b[7:0];
    b = 255;
    while (b >= 0 && cum[b] > n - fh) b--;
    if (b < 255) b++;
    cut_hi = b[7:0];
  endfunction

  function automatic logic [7:0] map_value(logic [7:0] x);
    int lo, hi, tmn, tmx, num, den, q, s;
    lo = cut_lo; hi = cut_hi; tmn = m_tmin; tmx = m_tmax;
    if (tmn == tmx) return m_tmin;
    if (hi <= lo) return 8'((tmn + tmx) / 2);
    if (int'(x) < lo) return m_tmin;
    if (int'(x) >= hi) return m_tmax;
    num = (int'(x) - lo) * (tmx - tmn);
    den = hi - lo;
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    s = tmn + q;
    return s[7:0];
  endfunction

  function automatic void stretch_step(hqcs_pkg::in_t it);
    hqcs_pkg::out_t r;
    if (it.operation == hqcs_pkg::OP_APPLY) begin
      r.kind = hqcs_pkg::KIND_PIXEL;
      r.pixel_out = map_value(it.pixel);
      r.low_bound = cut_lo;
      r.high_bound = cut_hi;
      expected_results.push_back(r);
      return;
    end
    if (hist[it.pixel] < MAXPIX) hist[it.pixel]++;
    if (pix_cnt < MAXPIX) pix_cnt++;
    if (it.pixel < run_min) run_min = it.pixel;
    if (it.pixel > run_max) run_max = it.pixel;
    if (!it.last) return;
    frame_bounds();
    foreach (hist[i]) hist[i] = 0;
    pix_cnt = 0; run_min = 8'd255; run_max = 8'd0;
    r.kind = hqcs_pkg::KIND_BOUNDS;
    r.pixel_out = 8'd0;
    r.low_bound = cut_lo;
    r.high_bound = cut_hi;
    expected_results.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) stretch_step(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, out_data);
          errors++;
        end else begin
          hqcs_pkg::out_t e;
          e = expected_results.pop_front();
          if (e.kind !== out_data.kind) begin
            $display("%0t kind mismatch: expected %0d actual %0d", $time, e.kind, out_data.kind);
            errors++;
          end
          if (e.pixel_out !== out_data.pixel_out) begin
            $display("%0t pixel_out mismatch: expected %0d actual %0d",
                     $time, e.pixel_out, out_data.pixel_out);
            errors++;
          end
          if (e.low_bound !== out_data.low_bound) begin
            $display("%0t low_bound mismatch: expected %0d actual %0d",
                     $time, e.low_bound, out_data.low_bound);
            errors++;
          end
          if (e.high_bound !== out_data.high_bound) begin
            $display("%0t high_bound mismatch: expected %0d actual %0d",
                     $time, e.high_bound, out_data.high_bound);
            errors++;
          end
        end
        if (results_seen >= 150 && !pressure_done && pending_items.size() > 50) begin
          pressure_done = 1;
          out_hold = 3000;
        end
      end
      if (out_hold > 0) begin
        out_hold = out_hold - 1;
        out_ready <= 1'b0;
      end else if (pick_gap() > 0) begin
        out_ready <= 1'b0;
        out_hold = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("[histogram_quantile_contrast_stretch] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      hqcs_pkg::REG_TARGET_MIN: m_tmin = val[7:0];
      hqcs_pkg::REG_TARGET_MAX: m_tmax = val[7:0];
      hqcs_pkg::REG_FLAT_LOW:   m_flat_lo = val;
      default:                  m_flat_hi = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_item(logic op, logic [7:0] px, logic lst);
    hqcs_pkg::in_t it;
    it.operation = op; it.pixel = px; it.last = lst;
    pending_items.push_back(it);
  endtask

  task automatic configure(int tmn, int tmx, int fl, int fh);
    write_reg(hqcs_pkg::REG_TARGET_MIN, 21'(tmn));
    write_reg(hqcs_pkg::REG_TARGET_MAX, 21'(tmx));
    write_reg(hqcs_pkg::REG_FLAT_LOW, 21'(fl));
    write_reg(hqcs_pkg::REG_FLAT_HIGH, 21'(fh));
  endtask

  int tmn_set [8] = '{0, 255, 40, 10, 0, 200, 0, 255};
  int tmx_set [8] = '{255, 0, 40, 200, 255, 30, 255, 255};
  int fl_set  [8] = '{0, 1, 2, 0, 1048576, 3, 1, 0};
  int fh_set  [8] = '{0, 1, 0, 3, 1048576, 5, 0, 2};

  initial begin
    int made, k, mode, base, spread;
    logic [7:0] px;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: reset bounds, single pixel frames, extremes
    push_item(hqcs_pkg::OP_APPLY, 8'd0, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd255, 1'b1);
    push_item(hqcs_pkg::OP_COLLECT, 8'd0, 1'b1);
    push_item(hqcs_pkg::OP_APPLY, 8'd0, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd128, 1'b0);
    push_item(hqcs_pkg::OP_COLLECT, 8'd255, 1'b0);
    push_item(hqcs_pkg::OP_COLLECT, 8'd0, 1'b0);
    push_item(hqcs_pkg::OP_COLLECT, 8'd7, 1'b1);
    push_item(hqcs_pkg::OP_APPLY, 8'd0, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd3, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd7, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd255, 1'b0);
    push_item(hqcs_pkg::OP_COLLECT, 8'd255, 1'b1);
    push_item(hqcs_pkg::OP_APPLY, 8'd254, 1'b0);
    drain();
    configure(20, 220, 1, 1);
    for (int i = 0; i < 6; i++) push_item(hqcs_pkg::OP_COLLECT, 8'(i * 50), i == 5);
    push_item(hqcs_pkg::OP_APPLY, 8'd49, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd100, 1'b0);
    push_item(hqcs_pkg::OP_APPLY, 8'd255, 1'b0);
    drain();
    made = 0;
    for (int ph = 0; made < RAND_ITEMS; ph++) begin
      if (ph < 8) configure(tmn_set[ph], tmx_set[ph], fl_set[ph], fh_set[ph]);
      else configure($urandom_range(255), $urandom_range(255),
                     $urandom_range(9), $urandom_range(9));
      for (int f = 0; f < 12; f++) begin
        k = $urandom_range(40, 1);
        mode = $urandom_range(2);
        base = $urandom_range(255);
        spread = $urandom_range(30, 1);
        for (int j = 0; j < k; j++) begin
          if (mode == 0) px = 8'($urandom_range(255));
          else px = 8'((base + $urandom_range(spread)) % 256);
          push_item(hqcs_pkg::OP_COLLECT, px, j == k - 1);
          if ($urandom_range(19) == 0)
            push_item(hqcs_pkg::OP_APPLY, 8'($urandom_range(255)), 1'b0);
        end
        k = $urandom_range(12);
        for (int j = 0; j < k; j++)
          push_item(hqcs_pkg::OP_APPLY, 8'($urandom_range(255)), $urandom_range(1));
      end
      made += pending_items.size();
      drain();
    end
    drain();
    if (errors == 0) begin
      $display("[histogram_quantile_contrast_stretch] OK");
    end else begin
      $display("[histogram_quantile_contrast_stretch] ERROR");
    end
    $finish;
  end
endmodule
